### rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// Needs signals named clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define TWC_AST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define TWC_AST_ALL(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/twc_pkg.sv
// Package of the text window cell engine: sizes, codes and reset values.
// Used by the top level and the checker.
`timescale 1ns / 1ps
package twc_pkg;
	localparam int MAX_ROWS_P  = 25;
	localparam int MAX_COLS_P  = 80;
	localparam int STORE_CELLS = MAX_ROWS_P * MAX_COLS_P;
	localparam int ADDR_W      = $clog2(STORE_CELLS);

	// request codes
	localparam logic [3:0] REQ_PUT     = 4'd0;
	localparam logic [3:0] REQ_NEWLINE = 4'd1;
	localparam logic [3:0] REQ_SETCUR  = 4'd2;
	localparam logic [3:0] REQ_MOVECUR = 4'd3;
	localparam logic [3:0] REQ_SCRDOWN = 4'd4;
	localparam logic [3:0] REQ_SCRUP   = 4'd5;
	localparam logic [3:0] REQ_CLEAR   = 4'd6;
	localparam logic [3:0] REQ_CLREND  = 4'd7;
	localparam logic [3:0] REQ_CLRLINE = 4'd8;
	localparam logic [3:0] REQ_SPAN    = 4'd9;
	localparam logic [3:0] REQ_READ    = 4'd10;
	localparam logic [3:0] REQ_REPAINT = 4'd11;

	// span modes
	localparam logic [1:0] SPAN_COUNT = 2'd0;
	localparam logic [1:0] SPAN_LINE  = 2'd1;
	localparam logic [1:0] SPAN_WIN   = 2'd2;
	localparam logic [1:0] SPAN_BAD   = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_ROWS  = 3'd0;
	localparam logic [2:0] CFG_COLS  = 3'd1;
	localparam logic [2:0] CFG_WATTR = 3'd2;
	localparam logic [2:0] CFG_LOCK  = 3'd3;
	localparam logic [2:0] CFG_BLANK = 3'd4;

	// reset values
	localparam logic [4:0] RST_ROWS  = 5'd25;
	localparam logic [6:0] RST_COLS  = 7'd80;
	localparam logic [7:0] RST_WATTR = 8'd7;
	localparam logic [7:0] RST_BLANK = 8'd32;
	localparam logic [15:0] RST_CELL = {RST_WATTR, RST_BLANK};
endpackage

### rtl/core/twc_req_if.sv
// Request channel of the text window cell engine.
// No dependencies.
`timescale 1ns / 1ps
interface twc_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         req_type;
	logic [7:0]         char_code;
	logic [7:0]         attr;
	logic [10:0]        position;
	logic signed [11:0] offset;
	logic [4:0]         row;
	logic [6:0]         col;
	logic [10:0]        span_len;
	logic [1:0]         span_mode;

	modport source (output valid, req_type, char_code, attr, position, offset, row, col,
		span_len, span_mode, input ready);
	modport sink (input valid, req_type, char_code, attr, position, offset, row, col,
		span_len, span_mode, output ready);
endinterface

### rtl/core/twc_rsp_if.sv
// Response channel of the text window cell engine.
// No dependencies.
`timescale 1ns / 1ps
interface twc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] cell_char;
	logic [7:0] cell_attr;
	logic [4:0] cursor_row;
	logic [6:0] cursor_col;
	logic       applied;

	modport source (output valid, cell_char, cell_attr, cursor_row, cursor_col, applied,
		input ready);
	modport sink (input valid, cell_char, cell_attr, cursor_row, cursor_col, applied,
		output ready);
endinterface

### rtl/core/twc_cfg_if.sv
// Configuration write channel of the text window cell engine.
// No dependencies.
`timescale 1ns / 1ps
interface twc_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/text_window_cell_engine.sv
// Channel | dir | payload                                     | handshake
// req     | in  | req_type char_code attr position offset ... | valid/ready
// rsp     | out | cell_char cell_attr cursor_row/col applied   | valid/ready
// cfg     | in  | index data                                  | valid/ready
//
// One item at a time. Every item runs a division of its operand by the column
// count; items that touch cells then walk the cell memory at one cell per cycle
// and drain (1 cell for put and read, up to 2000 for scrolls and clears); every
// item ends with a division of the cursor, and its result goes to the output
// register before the next item can be taken.
// After reset a clearing pass fills the memory; no item is taken.
// A waiting result sits in the output register; the next item is still taken.
// Depends on twc_pkg and the three channel interfaces.
`timescale 1ns / 1ps
module text_window_cell_engine (
	input logic clk,
	input logic arst_n,
	twc_req_if.sink   req,
	twc_rsp_if.source rsp,
	twc_cfg_if.sink   cfg
);
	import twc_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_EXEC = 6'b000100,
		ST_WALK = 6'b001000,
		ST_POST = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	typedef enum logic [1:0] {WK_FILL, WK_COPY, WK_PAINT, WK_READ} walk_kind_t;

	state_t state_q;

	// configuration
	logic [4:0] rows_q;
	logic [6:0] cols_q;
	logic [7:0] wattr_q, blank_q;
	logic       lock_q, cfgchk_q;

	// latched item
	logic [3:0]         rq_type_q;
	logic [7:0]         rq_ch_q, rq_attr_q;
	logic [10:0]        rq_pos_q, rq_len_q;
	logic signed [11:0] rq_off_q;
	logic [1:0]         rq_mode_q;
	logic [11:0]        start_q;

	logic [ADDR_W-1:0] cur_q;
	logic              applied_q, post_q, endchk_q, boot_q;
	logic [7:0]        rc_q, ra_q;

	// divider
	logic [10:0] div_a_q, div_q_q;
	logic [7:0]  div_r_q;
	logic [3:0]  div_cnt_q;

	// walk engine
	logic [ADDR_W-1:0] walk_src_q;
	logic [10:0]       walk_cnt_q;
	logic              walk_up_q;
	logic signed [11:0] walk_delta_q;
	walk_kind_t        walk_kind_q;
	logic [15:0]       walk_val_q;
	logic              then_fill_q;
	logic [ADDR_W-1:0] fill_src_q;
	logic [10:0]       fill_cnt_q;

	// memory pipeline
	logic [15:0]       mem [STORE_CELLS];
	logic [15:0]       rd_s1;
	logic              s1_v;
	logic [ADDR_W-1:0] s1_addr;
	walk_kind_t        s1_kind;
	logic [15:0]       wdata;

	// output register
	logic       rsp_v_q;
	logic [7:0] o_char_q, o_attr_q;
	logic [4:0] o_row_q;
	logic [6:0] o_col_q;
	logic       o_app_q;

	// effective window size
	logic [4:0]  rows_e;
	logic [6:0]  cols_e;
	logic [11:0] c12, n_w, start_w, nl_w;
	always_comb begin
		rows_e = (rows_q == 5'd0) ? 5'd1 : (rows_q > 5'(MAX_ROWS_P)) ? 5'(MAX_ROWS_P) : rows_q;
		cols_e = (cols_q == 7'd0) ? 7'd1 : (cols_q > 7'(MAX_COLS_P)) ? 7'(MAX_COLS_P) : cols_q;
		c12 = 12'(cols_e);
		n_w = 12'(rows_e) * c12;
		start_w = 12'(req.row) * c12 + 12'(req.col);
		nl_w = (12'(div_q_q[4:0]) + 12'd1) * c12;
	end

	// one restoring division step
	logic [7:0] rem_sh, rem_nx;
	logic       div_ge;
	always_comb begin
		rem_sh = {div_r_q[6:0], div_a_q[10]};
		div_ge = rem_sh >= {1'b0, cols_e};
		rem_nx = div_ge ? rem_sh - {1'b0, cols_e} : rem_sh;
	end

	// movecur target and span end
	logic signed [12:0] np_w;
	logic [12:0] s13, e_cnt, e_line, e_end;
	always_comb begin
		np_w = $signed({2'b00, cur_q}) + 13'(rq_off_q);
		s13 = {1'b0, start_q};
		e_cnt = (rq_len_q == 11'd0) ? s13 : s13 + 13'(rq_len_q) - 13'd1;
		e_line = s13 + 13'(cols_e) - 13'(div_r_q[6:0]) - 13'd1;
		unique case (rq_mode_q)
			SPAN_LINE: e_end = e_line;
			SPAN_WIN:  e_end = 13'(n_w) - 13'd1;
			default:   e_end = e_cnt;
		endcase
		if (e_end > 13'(n_w) - 13'd1) begin
			e_end = 13'(n_w) - 13'd1;
		end
	end

	// write data of the walk stage
	always_comb begin
		unique case (s1_kind)
			WK_COPY:  wdata = rd_s1;
			WK_PAINT: wdata = {walk_val_q[15:8], rd_s1[7:0]};
			default:  wdata = walk_val_q;
		endcase
	end

	// cell memory: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (s1_v && s1_kind != WK_READ) begin
			mem[s1_addr] <= wdata;
		end
		if (state_q == ST_WALK && walk_cnt_q != 11'd0) begin
			rd_s1 <= mem[walk_src_q];
		end
	end

	assign req.ready = (state_q == ST_IDLE) && !cfgchk_q;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_v_q;
	assign rsp.cell_char = o_char_q;
	assign rsp.cell_attr = o_attr_q;
	assign rsp.cursor_row = o_row_q;
	assign rsp.cursor_col = o_col_q;
	assign rsp.applied = o_app_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WALK;
			rows_q <= RST_ROWS;
			cols_q <= RST_COLS;
			wattr_q <= RST_WATTR;
			blank_q <= RST_BLANK;
			lock_q <= 1'b1;
			cfgchk_q <= 1'b0;
			cur_q <= '0;
			boot_q <= 1'b1;
			walk_src_q <= '0;
			walk_cnt_q <= 11'(STORE_CELLS);
			walk_up_q <= 1'b1;
			walk_delta_q <= '0;
			walk_kind_q <= WK_FILL;
			walk_val_q <= RST_CELL;
			then_fill_q <= 1'b0;
			s1_v <= 1'b0;
			rsp_v_q <= 1'b0;
			post_q <= 1'b0;
			endchk_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			// walk stage pipeline
			s1_v <= (state_q == ST_WALK) && (walk_cnt_q != 11'd0);
			s1_addr <= ADDR_W'($signed({1'b0, walk_src_q}) + walk_delta_q);
			s1_kind <= walk_kind_q;
			if (s1_v && s1_kind == WK_READ) begin
				rc_q <= rd_s1[7:0];
				ra_q <= rd_s1[15:8];
			end

			if (rsp_v_q && rsp.ready && state_q != ST_OUT) begin
				rsp_v_q <= 1'b0;
			end

			// configuration writes; cursor checked in the next cycle
			if (cfg.valid) begin
				cfgchk_q <= 1'b1;
				// the previous write still owes its cursor check
				if (cfgchk_q && 12'(cur_q) >= n_w) begin
					cur_q <= '0;
				end
				unique case (cfg.index)
					CFG_ROWS:  rows_q <= cfg.data[4:0];
					CFG_COLS:  cols_q <= cfg.data[6:0];
					CFG_WATTR: wattr_q <= cfg.data;
					CFG_LOCK:  lock_q <= cfg.data[0];
					CFG_BLANK: blank_q <= cfg.data;
					default:   ;
				endcase
			end else if (cfgchk_q) begin
				cfgchk_q <= 1'b0;
				if (12'(cur_q) >= n_w) begin
					cur_q <= '0;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						rq_type_q <= req.req_type;
						rq_ch_q <= req.char_code;
						rq_attr_q <= req.attr;
						rq_pos_q <= req.position;
						rq_off_q <= req.offset;
						rq_len_q <= req.span_len;
						rq_mode_q <= req.span_mode;
						start_q <= start_w;
						applied_q <= 1'b1;
						rc_q <= '0;
						ra_q <= '0;
						post_q <= 1'b0;
						endchk_q <= 1'b0;
						div_a_q <= (req.req_type == REQ_SPAN) ? start_w[10:0] : cur_q;
						div_q_q <= '0;
						div_r_q <= '0;
						div_cnt_q <= 4'd11;
						state_q <= ST_DIV;
					end
				end

				ST_DIV: begin
					div_a_q <= {div_a_q[9:0], 1'b0};
					div_q_q <= {div_q_q[9:0], div_ge};
					div_r_q <= rem_nx;
					div_cnt_q <= div_cnt_q - 4'd1;
					if (div_cnt_q == 4'd1) begin
						state_q <= post_q ? ST_OUT : ST_EXEC;
					end
				end

				ST_EXEC: begin
					walk_up_q <= 1'b1;
					walk_delta_q <= '0;
					walk_kind_q <= WK_FILL;
					walk_val_q <= {wattr_q, blank_q};
					then_fill_q <= 1'b0;
					state_q <= ST_POST;
					unique case (rq_type_q)
						REQ_PUT: begin
							walk_src_q <= cur_q;
							walk_cnt_q <= 11'd1;
							walk_val_q <= {rq_attr_q, rq_ch_q};
							cur_q <= cur_q + 1'b1;
							endchk_q <= 1'b1;
							state_q <= ST_WALK;
						end
						REQ_NEWLINE: begin
							cur_q <= nl_w[ADDR_W-1:0];
							endchk_q <= 1'b1;
						end
						REQ_SETCUR: begin
							if (12'(rq_pos_q) < n_w) cur_q <= rq_pos_q;
							else applied_q <= 1'b0;
						end
						REQ_MOVECUR: begin
							if (!np_w[12] && np_w[11:0] < n_w) cur_q <= np_w[ADDR_W-1:0];
							else applied_q <= 1'b0;
						end
						REQ_SCRDOWN: begin
							walk_kind_q <= WK_COPY;
							walk_src_q <= ADDR_W'(c12);
							walk_cnt_q <= 11'(n_w - c12);
							walk_delta_q <= -$signed(c12);
							then_fill_q <= 1'b1;
							fill_src_q <= ADDR_W'(n_w - c12);
							fill_cnt_q <= 11'(c12);
							cur_q <= ADDR_W'(n_w - c12);
							state_q <= ST_WALK;
						end
						REQ_SCRUP: begin
							walk_kind_q <= WK_COPY;
							walk_src_q <= ADDR_W'(n_w - c12 - 12'd1);
							walk_cnt_q <= 11'(n_w - c12);
							walk_up_q <= 1'b0;
							walk_delta_q <= $signed(c12);
							then_fill_q <= 1'b1;
							fill_src_q <= '0;
							fill_cnt_q <= 11'(c12);
							cur_q <= '0;
							state_q <= ST_WALK;
						end
						REQ_CLEAR: begin
							walk_src_q <= '0;
							walk_cnt_q <= 11'(STORE_CELLS);
							cur_q <= '0;
							state_q <= ST_WALK;
						end
						REQ_CLREND: begin
							walk_src_q <= cur_q;
							walk_cnt_q <= 11'(STORE_CELLS) - 11'(cur_q);
							state_q <= ST_WALK;
						end
						REQ_CLRLINE: begin
							walk_src_q <= cur_q;
							walk_cnt_q <= 11'(cols_e) - 11'(div_r_q[6:0]);
							state_q <= ST_WALK;
						end
						REQ_SPAN: begin
							if (start_q >= n_w || rq_mode_q == SPAN_BAD) begin
								applied_q <= 1'b0;
							end else begin
								walk_kind_q <= WK_PAINT;
								walk_src_q <= start_q[ADDR_W-1:0];
								walk_cnt_q <= 11'(e_end - s13 + 13'd1);
								walk_val_q <= {rq_attr_q, 8'h00};
								state_q <= ST_WALK;
							end
						end
						REQ_READ: begin
							if (12'(rq_pos_q) < n_w) begin
								walk_kind_q <= WK_READ;
								walk_src_q <= rq_pos_q;
								walk_cnt_q <= 11'd1;
								state_q <= ST_WALK;
							end else begin
								applied_q <= 1'b0;
							end
						end
						REQ_REPAINT: begin
							walk_kind_q <= WK_PAINT;
							walk_src_q <= '0;
							walk_cnt_q <= 11'(n_w);
							walk_val_q <= {wattr_q, 8'h00};
							state_q <= ST_WALK;
						end
						default: applied_q <= 1'b0;
					endcase
				end

				ST_WALK: begin
					if (walk_cnt_q != 11'd0) begin
						walk_cnt_q <= walk_cnt_q - 11'd1;
						walk_src_q <= walk_up_q ? walk_src_q + 1'b1 : walk_src_q - 1'b1;
					end else if (!s1_v) begin
						if (then_fill_q) begin
							then_fill_q <= 1'b0;
							walk_kind_q <= WK_FILL;
							walk_src_q <= fill_src_q;
							walk_cnt_q <= fill_cnt_q;
							walk_up_q <= 1'b1;
							walk_delta_q <= '0;
							walk_val_q <= {wattr_q, blank_q};
						end else if (boot_q) begin
							boot_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_POST;
						end
					end
				end

				ST_POST: begin
					// end of window after put or newline
					if (endchk_q && 12'(cur_q) >= n_w) begin
						endchk_q <= 1'b0;
						if (lock_q) begin
							cur_q <= '0;
						end else begin
							walk_kind_q <= WK_COPY;
							walk_src_q <= ADDR_W'(c12);
							walk_cnt_q <= 11'(n_w - c12);
							walk_up_q <= 1'b1;
							walk_delta_q <= -$signed(c12);
							then_fill_q <= 1'b1;
							fill_src_q <= ADDR_W'(n_w - c12);
							fill_cnt_q <= 11'(c12);
							cur_q <= ADDR_W'(n_w - c12);
							state_q <= ST_WALK;
						end
					end else begin
						endchk_q <= 1'b0;
						post_q <= 1'b1;
						div_a_q <= cur_q;
						div_q_q <= '0;
						div_r_q <= '0;
						div_cnt_q <= 4'd11;
						state_q <= ST_DIV;
					end
				end

				ST_OUT: begin
					if (!rsp_v_q || rsp.ready) begin
						rsp_v_q <= 1'b1;
						o_char_q <= rc_q;
						o_attr_q <= ra_q;
						o_row_q <= div_q_q[4:0];
						o_col_q <= div_r_q[6:0];
						o_app_q <= applied_q;
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/core/twc_checker.sv
// Port-level checks of the text window cell engine, bound to the top level.
// Depends on twc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module twc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] cell_char,
	input logic [7:0] cell_attr,
	input logic [4:0] cursor_row,
	input logic [6:0] cursor_col,
	input logic       applied
);
	import twc_pkg::*;

	// a stalled result holds
	`TWC_AST(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(cell_char) && $stable(cell_attr) && $stable(cursor_row) && $stable(cursor_col) && $stable(applied), "result changed while stalled")
	// one item at a time
	`TWC_AST(a_one_item, req_valid && req_ready |=> !req_ready, "second item taken while busy")
	// ignored commands carry no cell
	`TWC_AST(a_ign_zero, rsp_valid && !applied |-> cell_char == 8'd0 && cell_attr == 8'd0, "cell data on ignored item")
	// cursor inside the largest window
	`TWC_AST(a_cur_rng, rsp_valid |-> cursor_row < 5'(MAX_ROWS_P) && cursor_col < 7'(MAX_COLS_P), "cursor out of range")
endmodule

bind text_window_cell_engine twc_checker u_twc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.cell_char(rsp.cell_char),
	.cell_attr(rsp.cell_attr),
	.cursor_row(rsp.cursor_row),
	.cursor_col(rsp.cursor_col),
	.applied(rsp.applied)
);
